FILE: sv/mawc_pkg.sv
// Package for the Metropolis acceptance judge with geometric cooling.
// Holds field widths, reset values, register indexes, the exp table and the
// sequencer state type. No dependencies.
package mawc_pkg;

    localparam int TEMP_W   = 32;
    localparam int RATE_W   = 17;
    localparam int RAND_W   = 16;
    localparam int PROB_W   = 17;
    localparam int QUOT_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic [TEMP_W-1:0] TEMP_RESET = 32'd65536;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd52429;
    localparam logic [MUL_B_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam logic [PROB_W-1:0] PROB_ONE   = 17'd65536;
    localparam logic [4:0]        SHIFT_ZERO = 5'd17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_RATE = 2'd1;

    // Operation codes
    localparam logic OP_JUDGE = 1'b0;
    localparam logic OP_COOL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RANGE,
        ST_DIV,
        ST_LOG,
        ST_SPLIT,
        ST_EXP,
        ST_EXP_RND,
        ST_FINAL,
        ST_COOL,
        ST_DONE
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

    // 2^(-2^(-k-1)) in Q0.16 for fraction bit 7-k
    function automatic logic [15:0] pow2_neg_frac(input logic [2:0] k);
        logic [15:0] c;
        case (k)
            3'd0:    c = 16'd46341;
            3'd1:    c = 16'd55109;
            3'd2:    c = 16'd60097;
            3'd3:    c = 16'd62757;
            3'd4:    c = 16'd64132;
            3'd5:    c = 16'd64830;
            3'd6:    c = 16'd65182;
            default: c = 16'd65359;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/mawc_mul.sv
// Shared registered multiplier for cooling, log2 scaling and exp steps.
// Depends on mawc_pkg for operand widths.
module mawc_mul (
    input  logic                          aclk,
    input  logic [mawc_pkg::MUL_A_W-1:0]  a,
    input  logic [mawc_pkg::MUL_B_W-1:0]  b,
    output logic [mawc_pkg::PROD_W-1:0]   prod
);

    logic [mawc_pkg::PROD_W-1:0] prod_reg;

    // Register the product, one multiply per cycle
    always_ff @(posedge aclk) begin
        prod_reg <= {{mawc_pkg::MUL_B_W{1'b0}}, a} * {{mawc_pkg::MUL_A_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

FILE: sv/mawc_div.sv
// Restoring divider: quotient of (rise << 16) / temp, one bit per cycle.
// Caller guarantees the quotient fits in QUOT_W bits. Depends on mawc_pkg.
module mawc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mawc_pkg::TEMP_W-1:0]   rise,
    input  logic [mawc_pkg::TEMP_W-1:0]   temp,
    output mawc_pkg::div_stat_t           stat
);

    logic [mawc_pkg::TEMP_W-1:0] rem_reg,  rem_next;
    logic [mawc_pkg::QUOT_W-1:0] low_reg,  low_next;
    logic [mawc_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [4:0]                  cnt_reg,  cnt_next;
    logic                        busy_reg, busy_next;
    logic [mawc_pkg::TEMP_W:0]   shifted;
    logic [mawc_pkg::TEMP_W+1:0] trial;
    logic                        last;

    assign shifted = {rem_reg, low_reg[mawc_pkg::QUOT_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, temp};
    assign last    = (cnt_reg == 5'(mawc_pkg::QUOT_W - 1));

    // Load on start, then one compare and subtract per cycle
    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = {4'b0000, rise[mawc_pkg::TEMP_W-1:4]};
            low_next  = {rise[3:0], 16'd0};
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[mawc_pkg::TEMP_W+1]) begin
                rem_next = trial[mawc_pkg::TEMP_W-1:0];
            end else begin
                rem_next = shifted[mawc_pkg::TEMP_W-1:0];
            end
            quot_next = {quot_reg[mawc_pkg::QUOT_W-2:0], ~trial[mawc_pkg::TEMP_W+1]};
            low_next  = {low_reg[mawc_pkg::QUOT_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 5'd1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign stat.done = busy_reg && last;
    assign stat.quot = quot_reg;

endmodule

FILE: sv/metropolis_acceptor_with_cooling.sv
// Channel    Direction  Payload
// s_*        in         operation, old_cost, new_cost, uniform_random
// m_*        out        accepted, temperature_now
// cfg_*      in         cfg_index, cfg_data (0 initial temperature, 1 cooling rate)
//
// One transaction at a time. A judge on a drop, an equal cost or a zero temperature
// goes from the check state straight to done; a cool or an out-of-range ratio first
// passes the cool or the range state; a rise runs 20 serial divider steps,
// one log2 multiply, then 8 exp steps, each set fraction bit adding a multiply and
// a rounding step, and a final compare. s_ready rises with the result.
// Reset is synchronous and loads the temperature with 1.0. A stalled result holds
// the sequencer in its last state; s_ready stays low until the sequencer returns
// to idle.
module metropolis_acceptor_with_cooling (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [mawc_pkg::TEMP_W-1:0]       s_old_cost,
    input  logic [mawc_pkg::TEMP_W-1:0]       s_new_cost,
    input  logic [mawc_pkg::RAND_W-1:0]       s_uniform_random,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [mawc_pkg::TEMP_W-1:0]       m_temperature_now,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mawc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mawc_pkg::TEMP_W-1:0]       cfg_data
);

    mawc_pkg::state_t state_reg, state_next;

    logic [mawc_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [mawc_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic                        op_reg;
    logic [mawc_pkg::TEMP_W-1:0] old_reg, new_reg;
    logic [mawc_pkg::RAND_W-1:0] rnd_reg;
    logic [mawc_pkg::TEMP_W-1:0] rise_reg, rise_next;
    logic [4:0]                  n_reg, n_next;
    logic [7:0]                  f_reg, f_next;
    logic [mawc_pkg::PROB_W-1:0] p_reg, p_next;
    logic [2:0]                  k_reg, k_next;
    logic                        acc_reg, acc_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        m_acc_reg, m_acc_next;
    logic [mawc_pkg::TEMP_W-1:0] m_temp_reg, m_temp_next;

    logic [mawc_pkg::MUL_A_W-1:0] mul_a;
    logic [mawc_pkg::MUL_B_W-1:0] mul_b;
    logic [mawc_pkg::PROD_W-1:0]  prod;
    logic                         div_start;
    mawc_pkg::div_stat_t          div_stat;

    logic                         in_fire;
    logic                         out_free;
    logic [33:0]                  rnd_sum;
    logic [mawc_pkg::PROB_W-1:0]  p_shift;

    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == mawc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rnd_sum   = {1'b0, prod[32:0]} + 34'd32768;
    assign p_shift   = (n_reg >= mawc_pkg::SHIFT_ZERO) ? '0 : (p_reg >> n_reg);

    mawc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mawc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .rise    (rise_reg),
        .temp    (temp_reg),
        .stat    (div_stat)
    );

    // Sequencer: next state, datapath updates and shared unit operands
    always_comb begin
        state_next   = state_reg;
        temp_next    = temp_reg;
        rate_next    = rate_reg;
        rise_next    = rise_reg;
        n_next       = n_reg;
        f_next       = f_reg;
        p_next       = p_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_acc_next   = m_acc_reg;
        m_temp_next  = m_temp_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mawc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = mawc_pkg::ST_CHECK;
                end
            end
            mawc_pkg::ST_CHECK: begin
                acc_next = 1'b0;
                if (op_reg == mawc_pkg::OP_COOL) begin
                    mul_a      = temp_reg;
                    mul_b      = rate_reg;
                    state_next = mawc_pkg::ST_COOL;
                end else if (new_reg < old_reg) begin
                    acc_next   = 1'b1;
                    state_next = mawc_pkg::ST_DONE;
                end else if (new_reg == old_reg || temp_reg == '0) begin
                    state_next = mawc_pkg::ST_DONE;
                end else begin
                    rise_next  = new_reg - old_reg;
                    state_next = mawc_pkg::ST_RANGE;
                end
            end
            mawc_pkg::ST_RANGE: begin
                // Ratio of 16 or more gives zero probability
                if ({4'b0000, rise_reg} >= {temp_reg, 4'b0000}) begin
                    state_next = mawc_pkg::ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = mawc_pkg::ST_DIV;
                end
            end
            mawc_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = mawc_pkg::ST_LOG;
                end
            end
            mawc_pkg::ST_LOG: begin
                mul_a      = {{(mawc_pkg::MUL_A_W - mawc_pkg::QUOT_W){1'b0}}, div_stat.quot};
                mul_b      = mawc_pkg::LOG2E_Q16;
                state_next = mawc_pkg::ST_SPLIT;
            end
            mawc_pkg::ST_SPLIT: begin
                n_next     = prod[36:32];
                f_next     = prod[31:24];
                p_next     = mawc_pkg::PROB_ONE;
                k_next     = 3'd0;
                state_next = mawc_pkg::ST_EXP;
            end
            mawc_pkg::ST_EXP: begin
                if (f_reg[7]) begin
                    mul_a      = {15'd0, p_reg};
                    mul_b      = {1'b0, mawc_pkg::pow2_neg_frac(k_reg)};
                    state_next = mawc_pkg::ST_EXP_RND;
                end else begin
                    f_next = {f_reg[6:0], 1'b0};
                    k_next = k_reg + 3'd1;
                    if (k_reg == 3'd7) begin
                        state_next = mawc_pkg::ST_FINAL;
                    end
                end
            end
            mawc_pkg::ST_EXP_RND: begin
                // Round the product back to Q16
                p_next = rnd_sum[32:16];
                f_next = {f_reg[6:0], 1'b0};
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7) begin
                    state_next = mawc_pkg::ST_FINAL;
                end else begin
                    state_next = mawc_pkg::ST_EXP;
                end
            end
            mawc_pkg::ST_FINAL: begin
                acc_next   = ({1'b0, rnd_reg} < p_shift);
                state_next = mawc_pkg::ST_DONE;
            end
            mawc_pkg::ST_COOL: begin
                // Saturate the scaled temperature
                if (prod[48]) begin
                    temp_next = '1;
                end else begin
                    temp_next = prod[47:16];
                end
                state_next = mawc_pkg::ST_DONE;
            end
            mawc_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = acc_reg;
                    m_temp_next  = temp_reg;
                    state_next   = mawc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mawc_pkg::ST_IDLE;
            end
        endcase

        // Register writes
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mawc_pkg::CFG_INIT_TEMP: temp_next = cfg_data;
                mawc_pkg::CFG_COOL_RATE: rate_next = cfg_data[mawc_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mawc_pkg::ST_IDLE;
            temp_reg    <= mawc_pkg::TEMP_RESET;
            rate_reg    <= mawc_pkg::RATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            temp_reg    <= temp_next;
            rate_reg    <= rate_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= s_operation;
            old_reg <= s_old_cost;
            new_reg <= s_new_cost;
            rnd_reg <= s_uniform_random;
        end
        rise_reg   <= rise_next;
        n_reg      <= n_next;
        f_reg      <= f_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        m_acc_reg  <= m_acc_next;
        m_temp_reg <= m_temp_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_acc_reg;
    assign m_temperature_now = m_temp_reg;

endmodule

FILE: sv/mawc_checker.sv
// Port-level checks for metropolis_acceptor_with_cooling, bound to the top.
// Depends on mawc_pkg for port widths.
module mawc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_accepted,
    input logic [mawc_pkg::TEMP_W-1:0]       m_temperature_now,
    input logic                              cfg_ready
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accepted)
            && $stable(m_temperature_now))
        else $error("stalled result changed");

    // Go busy after each accepted transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready after accept");

    // No result straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Register port never stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind metropolis_acceptor_with_cooling mawc_checker u_mawc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_accepted        (m_accepted),
    .m_temperature_now (m_temperature_now),
    .cfg_ready         (cfg_ready)
);

FILE: bench/tb_metropolis_acceptor_with_cooling.sv
// Testbench for metropolis_acceptor_with_cooling: directed and random judge and cool
// transactions, each result checked against an in-bench fixed-point predictor.
// Depends on mawc_pkg and the block's RTL.
module tb_metropolis_acceptor_with_cooling;

    localparam int MAX_GAP       = 18;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 850;
    // Margin after the last result, enough for the longest judge
    localparam int SETTLE_CYCLES = 60;
    // Slowest correct run: ~880 transactions, each with its send gap, the block's own time
    // and result stalls, plus config writes; the limit takes several times that
    localparam int CYCLE_LIMIT   = 500000;

    // Reset values of the two registers
    localparam logic [mawc_pkg::TEMP_W-1:0] TEMP_AT_RESET = 32'd65536;
    localparam logic [mawc_pkg::RATE_W-1:0] RATE_AT_RESET = 17'd52429;
    localparam logic [16:0]                 LOG2E         = 17'd94548;
    localparam logic [mawc_pkg::PROB_W-1:0] CERTAIN       = 17'd65536;
    // 2^(-2^(b-8)) in Q0.16, slice b serves fraction bit b
    localparam logic [8*16-1:0] EXP_STEPS = {16'd46341, 16'd55109, 16'd60097, 16'd62757,
                                             16'd64132, 16'd64830, 16'd65182, 16'd65359};

    typedef logic [mawc_pkg::RAND_W-1:0] rnd_t;
    typedef logic [mawc_pkg::RATE_W-1:0] rate_t;

    typedef struct packed {
        logic                        op;
        logic [mawc_pkg::TEMP_W-1:0] old_cost;
        logic [mawc_pkg::TEMP_W-1:0] new_cost;
        logic [mawc_pkg::RAND_W-1:0] rnd;
    } move_t;

    typedef struct packed {
        logic                        accepted;
        logic [mawc_pkg::TEMP_W-1:0] temperature;
    } outcome_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_operation;
    logic [mawc_pkg::TEMP_W-1:0]    s_old_cost;
    logic [mawc_pkg::TEMP_W-1:0]    s_new_cost;
    logic [mawc_pkg::RAND_W-1:0]    s_uniform_random;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_accepted;
    logic [mawc_pkg::TEMP_W-1:0]    m_temperature_now;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mawc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mawc_pkg::TEMP_W-1:0]    cfg_data;

    // Predicted block state
    logic [mawc_pkg::TEMP_W-1:0] model_temp;
    logic [mawc_pkg::RATE_W-1:0] model_rate;

    outcome_t pending_outcomes[$];
    outcome_t checked_outcome;
    int       mismatches   = 0;
    int       results_seen = 0;
    int       cycle_count  = 0;
    bit       steady       = 1'b0;

    metropolis_acceptor_with_cooling i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_old_cost        (s_old_cost),
        .s_new_cost        (s_new_cost),
        .s_uniform_random  (s_uniform_random),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_temperature_now (m_temperature_now),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Acceptance threshold in Q1.16 for a cost rise at a nonzero temperature
    function automatic logic [mawc_pkg::PROB_W-1:0] accept_threshold(
            input logic [mawc_pkg::TEMP_W-1:0] rise,
            input logic [mawc_pkg::TEMP_W-1:0] temp);
        logic [47:0]                 ratio;
        logic [63:0]                 log2_q8;
        logic [63:0]                 scaled;
        logic [7:0]                  frac;
        int unsigned                 whole;
        logic [mawc_pkg::PROB_W-1:0] p;
        ratio = {rise, 16'd0} / {16'd0, temp};
        // Ratio of 16 or more: treat the probability as zero
        if (ratio >= (48'd1 << 20))
            return '0;
        log2_q8 = ({16'd0, ratio} * {47'd0, LOG2E}) >> 24;
        whole   = log2_q8[39:8];
        frac    = log2_q8[7:0];
        p       = CERTAIN;
        // Apply one rounded factor per set fraction bit, top bit first
        for (int b = 7; b >= 0; b--) begin
            if (frac[b]) begin
                scaled = ({47'd0, p} * {48'd0, EXP_STEPS[b*16 +: 16]} + 64'd32768) >> 16;
                p      = scaled[mawc_pkg::PROB_W-1:0];
            end
        end
        if (whole >= 17)
            return '0;
        return p >> whole;
    endfunction

    // Advance the predicted state by one transaction and return its result
    function automatic outcome_t predict_outcome(input move_t mv);
        outcome_t    res;
        logic [48:0] cooled;
        res.accepted = 1'b0;
        if (mv.op == mawc_pkg::OP_COOL) begin
            cooled     = ({17'd0, model_temp} * {32'd0, model_rate}) >> 16;
            model_temp = (cooled > {17'd0, 32'hFFFF_FFFF}) ? '1
                                                          : cooled[mawc_pkg::TEMP_W-1:0];
        end else if (mv.new_cost < mv.old_cost) begin
            res.accepted = 1'b1;
        end else if (mv.new_cost > mv.old_cost && model_temp != '0) begin
            res.accepted = ({1'b0, mv.rnd} <
                            accept_threshold(mv.new_cost - mv.old_cost, model_temp));
        end
        res.temperature = model_temp;
        return res;
    endfunction

    function automatic move_t make_move(input logic op,
                                        input logic [mawc_pkg::TEMP_W-1:0] old_cost,
                                        input logic [mawc_pkg::TEMP_W-1:0] new_cost,
                                        input logic [mawc_pkg::RAND_W-1:0] rnd);
        move_t mv;
        mv.op       = op;
        mv.old_cost = old_cost;
        mv.new_cost = new_cost;
        mv.rnd      = rnd;
        return mv;
    endfunction

    // Random fraction placed at an offset from a threshold, clamped to Q0.16
    function automatic logic [mawc_pkg::RAND_W-1:0] rnd_near(
            input logic [mawc_pkg::PROB_W-1:0] p,
            input int offset);
        int v;
        v = int'(p);
        v = v + offset;
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[mawc_pkg::RAND_W-1:0];
    endfunction

    function automatic int pick_gap();
        if (steady)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Send one transaction; valid stays high afterwards so a gapless next one follows
    task automatic send_move(input move_t mv);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= mv.op;
        s_old_cost       <= mv.old_cost;
        s_new_cost       <= mv.new_cost;
        s_uniform_random <= mv.rnd;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(predict_outcome(mv));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    // Write the cooling rate, and the initial temperature first when asked
    task automatic write_config(input bit load_temp,
                                input logic [mawc_pkg::TEMP_W-1:0] init_temp,
                                input logic [mawc_pkg::RATE_W-1:0] rate);
        if (load_temp) begin
            cfg_valid <= 1'b1;
            cfg_index <= mawc_pkg::CFG_INIT_TEMP;
            cfg_data  <= init_temp;
            do @(posedge aclk); while (!cfg_ready);
            model_temp = init_temp;
        end
        cfg_valid <= 1'b1;
        cfg_index <= mawc_pkg::CFG_COOL_RATE;
        cfg_data  <= {{(mawc_pkg::TEMP_W-mawc_pkg::RATE_W){1'b0}}, rate};
        do @(posedge aclk); while (!cfg_ready);
        model_rate = rate;
        cfg_valid <= 1'b0;
    endtask

    // Reset temperature 1.0 and rate 0.8: drops, equal costs, rises, cools, extremes
    task automatic test_reset_values();
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0001_0000, 32'h0000_8000, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h1234_5678, 32'h1234_5678, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0001_0000, 32'h0001_8000, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0001_0000, 32'h0001_8000, 16'hFFFF));
        send_move(make_move(mawc_pkg::OP_COOL, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        // A one-LSB rise rounds to a certain accept even at the top random value
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0000_0000, 32'h0000_0001, 16'hFFFF));
        send_move(make_move(mawc_pkg::OP_COOL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    endtask

    // Zero temperature: rises rejected, drops accepted, cooling keeps zero
    task automatic test_zero_temperature();
        wait_idle();
        write_config(1'b1, 32'd0, RATE_AT_RESET);
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0000_0000, 32'h0000_0001, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0002_0000, 32'h0001_0000, 16'hFFFF));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0002_0000, 32'h0002_0000, 16'h0000));
        send_move(make_move(mawc_pkg::OP_COOL, 32'h0000_0000, 32'h0000_0000, 16'h0000));
    endtask

    // Cooling at the rate extremes: saturation, unity, smallest and zero rate
    task automatic test_cooling_limits();
        wait_idle();
        write_config(1'b1, 32'hFFFF_FFFF, 17'h1FFFF);
        send_move(make_move(mawc_pkg::OP_COOL, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000));
        wait_idle();
        write_config(1'b0, '0, 17'd65536);
        send_move(make_move(mawc_pkg::OP_COOL, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        wait_idle();
        write_config(1'b0, '0, 17'd1);
        send_move(make_move(mawc_pkg::OP_COOL, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        wait_idle();
        write_config(1'b0, '0, 17'd0);
        send_move(make_move(mawc_pkg::OP_COOL, 32'h0000_0000, 32'h0000_0000, 16'h0000));
    endtask

    // Ratio just under and at the cut-off, then random values on both sides of p
    task automatic test_probability_edges();
        logic [mawc_pkg::TEMP_W-1:0] rise;
        logic [mawc_pkg::PROB_W-1:0] p;
        wait_idle();
        write_config(1'b1, TEMP_AT_RESET, RATE_AT_RESET);
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0000_0000, 32'h000F_FFFF, 16'h0000));
        send_move(make_move(mawc_pkg::OP_JUDGE, 32'h0000_0000, 32'h0010_0000, 16'h0000));
        for (int i = 0; i < 3; i++) begin
            rise = 32'h4000 << (2 * i);
            p    = accept_threshold(rise, model_temp);
            send_move(make_move(mawc_pkg::OP_JUDGE, 32'h1000_0000, 32'h1000_0000 + rise,
                                rnd_near(p, -1)));
            send_move(make_move(mawc_pkg::OP_JUDGE, 32'h1000_0000, 32'h1000_0000 + rise,
                                rnd_near(p, 0)));
        end
    endtask

    // Mostly rises scaled to the current temperature, plus drops, ties, cools, noise
    function automatic move_t random_move();
        move_t                       mv;
        int unsigned                 sel;
        int                          off;
        logic [mawc_pkg::TEMP_W-1:0] a;
        logic [mawc_pkg::TEMP_W-1:0] b;
        logic [mawc_pkg::TEMP_W-1:0] rise;
        logic [63:0]                 span;
        logic [mawc_pkg::PROB_W-1:0] p;
        sel = $urandom_range(0, 19);
        a   = $urandom;
        b   = $urandom;
        mv  = make_move(mawc_pkg::OP_JUDGE, a, b, rnd_t'($urandom));
        if (sel < 2) begin
            mv.op = mawc_pkg::OP_COOL;
        end else if (sel < 5) begin
            mv.old_cost = (a > b) ? a : b;
            mv.new_cost = (a > b) ? b : a;
        end else if (sel == 5) begin
            mv.new_cost = a;
        end else if (sel > 7) begin
            span = ({32'd0, 32'($urandom_range(1, 20 << 16))} * {32'd0, model_temp}) >> 16;
            if (span == 0)
                rise = 32'd1;
            else if (span > 64'hFFFF_FFFF)
                rise = 32'hFFFF_FFFF;
            else
                rise = span[mawc_pkg::TEMP_W-1:0];
            mv.old_cost = $urandom_range(0, 32'hFFFF_FFFF - rise);
            mv.new_cost = mv.old_cost + rise;
            if ($urandom_range(0, 1) == 0) begin
                p   = (model_temp != '0) ? accept_threshold(rise, model_temp) : '0;
                off = $urandom_range(0, 4);
                mv.rnd = rnd_near(p, off - 2);
            end
        end
        return mv;
    endfunction

    function automatic logic [mawc_pkg::TEMP_W-1:0] random_init_temp();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel < 6)
            return $urandom_range(1, 32'h0004_0000);
        if (sel < 9)
            return $urandom_range(32'h0004_0000, 32'h0100_0000);
        return $urandom;
    endfunction

    function automatic logic [mawc_pkg::RATE_W-1:0] random_rate();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel == 2)
            return 17'd65536;
        if (sel == 3)
            return rate_t'($urandom);
        return rate_t'($urandom_range(45000, 65535));
    endfunction

    // Phases of random transactions, each after a full drain and a new setting
    task automatic test_random_annealing();
        int sent;
        int phase_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            write_config($urandom_range(0, 4) != 0, random_init_temp(), random_rate());
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 120);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                send_move(random_move());
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // Stall the result side, sometimes only once a result is already waiting
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 1) == 1)
                    do @(posedge aclk); while (!m_valid);
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d unexpected: accepted %0b temperature %h",
                             results_seen, m_accepted, m_temperature_now);
            end else begin
                checked_outcome = pending_outcomes.pop_front();
                if (m_accepted !== checked_outcome.accepted ||
                    m_temperature_now !== checked_outcome.temperature) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d: accepted exp %0b got %0b, temperature exp %h got %h",
                                 results_seen, checked_outcome.accepted, m_accepted,
                                 checked_outcome.temperature, m_temperature_now);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("metropolis_acceptor_with_cooling verification failed");
            $finish;
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_operation      = mawc_pkg::OP_JUDGE;
        s_old_cost       = '0;
        s_new_cost       = '0;
        s_uniform_random = '0;
        cfg_valid        = 1'b0;
        cfg_index        = mawc_pkg::CFG_INIT_TEMP;
        cfg_data         = '0;
        model_temp       = TEMP_AT_RESET;
        model_rate       = RATE_AT_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_zero_temperature();
        test_cooling_limits();
        test_probability_edges();
        test_random_annealing();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("metropolis_acceptor_with_cooling verification clean");
        else
            $display("metropolis_acceptor_with_cooling verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/mawc_pkg.sv
sv/mawc_mul.sv
sv/mawc_div.sv
sv/metropolis_acceptor_with_cooling.sv
sv/mawc_checker.sv
bench/tb_metropolis_acceptor_with_cooling.sv
